// File: sv/assert_macros.svh
// Assertion macros shared by the framer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("framer assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("framer forbidden condition seen");

`endif

// File: sv/cpf_pkg.sv
// Shared types, constants and CRC step for the CRC-16 packet framer.
// No dependencies; imported by every framer module.
package cpf_pkg;

    localparam logic [7:0]  START_MARKER = 8'hFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'h0000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        KIND_OPEN = 1'b0,
        KIND_DATA = 1'b1
    } cpf_kind_t;

    // One classified work item between front and back.
    typedef struct packed {
        cpf_kind_t  kind;
        logic       finish;     // frame closes after this item: append CRC
        logic [7:0] len_data;   // length on open, payload byte on data
        logic [7:0] code;       // command byte on open
    } cpf_entry_t;

    // CRC-16/XMODEM, one byte, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: sv/cpf_front.sv
// Front end of the framer: accepts input transactions, tracks the open frame
// and pushes classified items into the queue. Depends on cpf_pkg.
`include "assert_macros.svh"

module cpf_front
    import cpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,     // [0] cmd
    input  logic [7:0] code_in,
    input  logic [7:0] len_in,
    input  logic [7:0] data_in,
    input  logic       q_full,
    output logic       push,
    output cpf_entry_t push_entry
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        push            = 1'b0;
        push_entry      = '{kind: KIND_OPEN, finish: 1'b0, len_data: len_in, code: code_in};
        if (accept) begin
            if (s_tuser == KIND_OPEN) begin
                push                = 1'b1;
                push_entry.finish   = (len_in == 8'd0);
                frame_open_next     = (len_in != 8'd0);
                bytes_left_next     = len_in;
            end else if (frame_open_reg) begin
                push                = 1'b1;
                push_entry.kind     = KIND_DATA;
                push_entry.len_data = data_in;
                push_entry.finish   = (bytes_left_reg == 8'd1);
                bytes_left_next     = bytes_left_reg - 8'd1;
                frame_open_next     = (bytes_left_reg != 8'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    `ASSERT_PROP(a_open_matches_count, aclk, aresetn, frame_open_reg == (bytes_left_reg != 8'd0))

endmodule

// File: sv/cpf_queue.sv
// Short item queue between framer front and back, held in flip-flops.
// Depends on cpf_pkg for the entry type and depth.
`include "assert_macros.svh"

module cpf_queue
    import cpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cpf_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output cpf_entry_t head
);

    cpf_entry_t          entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `ASSERT_PROP(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QDEPTH))
    `ASSERT_PROP(a_ptr_span, aclk, aresetn, (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])

endmodule

// File: sv/cpf_back.sv
// Back end of the framer: expands queued items into frame bytes, runs the
// CRC one byte per unstalled cycle, owns output register. Uses cpf_pkg.
`include "assert_macros.svh"

module cpf_back
    import cpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  cpf_entry_t head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_LEN,
        PH_CODE,
        PH_CRCH,
        PH_CRCL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        pop           = 1'b0;
        if (out_free) begin
            m_tvalid_next = 1'b0;
            if (!q_empty) begin
                m_tvalid_next = 1'b1;
                m_tlast_next  = 1'b0;
                case (phase_reg)
                    PH_FIRST: begin
                        if (head.kind == KIND_OPEN) begin
                            m_tdata_next = START_MARKER;
                            phase_next   = PH_LEN;
                        end else begin
                            m_tdata_next = head.len_data;
                            crc_next     = crc_feed(crc_reg, head.len_data);
                            if (head.finish) begin
                                phase_next = PH_CRCH;
                            end else begin
                                pop = 1'b1;
                            end
                        end
                    end
                    PH_LEN: begin
                        m_tdata_next = head.len_data;
                        crc_next     = crc_feed(CRC_INIT, head.len_data);
                        phase_next   = PH_CODE;
                    end
                    PH_CODE: begin
                        m_tdata_next = head.code;
                        crc_next     = crc_feed(crc_reg, head.code);
                        if (head.finish) begin
                            phase_next = PH_CRCH;
                        end else begin
                            phase_next = PH_FIRST;
                            pop        = 1'b1;
                        end
                    end
                    PH_CRCH: begin
                        m_tdata_next = crc_reg[15:8];
                        phase_next   = PH_CRCL;
                    end
                    PH_CRCL: begin
                        m_tdata_next = crc_reg[7:0];
                        m_tlast_next = 1'b1;
                        crc_next     = CRC_INIT;
                        phase_next   = PH_FIRST;
                        pop          = 1'b1;
                    end
                    default: begin
                        phase_next    = PH_FIRST;
                        m_tvalid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            crc_reg      <= CRC_INIT;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tdata_reg  <= 8'd0;
        end else begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_PROP(a_mid_item_has_head, aclk, aresetn, (phase_reg != PH_FIRST) |-> !q_empty)
    `ASSERT_PROP(a_crc_clear_at_end, aclk, aresetn, (m_tvalid_reg && m_tlast_reg) |-> (crc_reg == CRC_INIT))

endmodule

// File: sv/crc16_packet_framer.sv
// Top level of the CRC-16 packet framer: front classifier, item queue, back sequencer.
// Depends on cpf_pkg, cpf_front, cpf_queue and cpf_back.
//
// Input stream (s_): s_tuser is cmd (0 opens a frame, 1 carries a payload byte);
// s_tdata holds command_code, frame_len and data_byte. An open item yields
// 0xFF, length, command, and when the length is zero also CRC high and low.
// Each payload item yields its byte; the last one of a frame is followed by the
// CRC-16/XMODEM high and low bytes over length, command and payload. Payload
// with no frame open is dropped; an open abandons any frame in progress.
// Output stream (m_): one frame byte per transaction, m_tlast on the CRC low byte.
// With the back end idle, an accepted item is written into the queue and its
// first byte is then registered in the output register.
// The back end emits one output byte per cycle while the queue holds an item
// and m_tready does not stall it. A four-entry queue lets input run ahead of
// output; s_tready falls only when the queue is full. A stalled m_tready holds
// the output register and, once the queue fills, the input side.
// Reset (aresetn low, synchronous): queue emptied, no frame open, CRC cleared.

module crc16_packet_framer
    import cpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] command_code, [15:8] frame_len, [23:16] data_byte
    input  logic        s_tuser,    // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast
);

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    cpf_entry_t push_entry;
    cpf_entry_t head;

    cpf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .code_in    (s_tdata[7:0]),
        .len_in     (s_tdata[15:8]),
        .data_in    (s_tdata[23:16]),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    cpf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/tb_crc16_packet_framer.sv
// Testbench for crc16_packet_framer: streams open and payload items through the framer
// and checks every frame byte and end mark against a self-built CRC-16/XMODEM frame model.
// Depends on cpf_pkg and crc16_packet_framer.

class frame_byte_tracker;
    localparam logic [7:0]  MARKER   = 8'hFF;
    localparam logic [15:0] POLY     = 16'h1021;

    logic [15:0] running_crc;
    logic [7:0]  bytes_to_go;
    bit          in_frame;
    logic [8:0]  due_bytes[$];   // {frame_end, out_byte}
    int          errors;

    function new();
        running_crc = '0;
        bytes_to_go = '0;
        in_frame    = 0;
        errors      = 0;
    endfunction

    // bit-serial, MSB first
    function logic [15:0] crc_xmodem_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ POLY;
        end
        return c;
    endfunction

    function void close_frame();
        due_bytes.push_back({1'b0, running_crc[15:8]});
        due_bytes.push_back({1'b1, running_crc[7:0]});
        in_frame    = 0;
        bytes_to_go = '0;
        running_crc = '0;
    endfunction

    function void accept_item(cpf_pkg::cpf_kind_t kind, logic [7:0] code,
                              logic [7:0] len, logic [7:0] data);
        if (kind == cpf_pkg::KIND_OPEN) begin
            running_crc = crc_xmodem_step(16'h0000, len);
            running_crc = crc_xmodem_step(running_crc, code);
            due_bytes.push_back({1'b0, MARKER});
            due_bytes.push_back({1'b0, len});
            due_bytes.push_back({1'b0, code});
            in_frame    = 1;
            bytes_to_go = len;
            if (len == 8'd0)
                close_frame();
        end else if (in_frame) begin
            running_crc = crc_xmodem_step(running_crc, data);
            due_bytes.push_back({1'b0, data});
            bytes_to_go = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'd0)
                close_frame();
        end
    endfunction

    function void match_byte(logic [7:0] out_byte, logic frame_end);
        logic [8:0] want;
        if (due_bytes.size() == 0) begin
            $error("unexpected frame byte %02h (frame_end %0b)", out_byte, frame_end);
            errors++;
            return;
        end
        want = due_bytes.pop_front();
        if (out_byte !== want[7:0]) begin
            $error("out_byte: expected %02h, actual %02h", want[7:0], out_byte);
            errors++;
        end
        if (frame_end !== want[8]) begin
            $error("frame_end: expected %0b, actual %0b", want[8], frame_end);
            errors++;
        end
    endfunction

    function int outstanding();
        return due_bytes.size();
    endfunction
endclass

module tb_crc16_packet_framer;
    timeunit 1ns;
    timeprecision 1ps;
    import cpf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    frame_byte_tracker book;
    int  gap_pct;
    int  stall_pct;
    bit  hold_req;
    bit  hold_done;
    int  cycle_count;
    int  items_sent;

    crc16_packet_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_crc16_packet_framer NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.match_byte(m_tdata, m_tlast);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(cpf_kind_t kind, logic [7:0] code, logic [7:0] len,
                             logic [7:0] data);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {data, len, code};
        do @(posedge aclk); while (!s_tready);
        book.accept_item(kind, code, len, data);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_open(logic [7:0] code, logic [7:0] len);
        send_item(KIND_OPEN, code, len, 8'($urandom));
    endtask

    task automatic send_payload(logic [7:0] data);
        send_item(KIND_DATA, 8'($urandom), 8'($urandom), data);
    endtask

    // mostly well-formed frames; some truncated, some stray payload items
    task automatic random_frames(int budget);
        int stop_at;
        int len;
        int count;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 6) begin
                send_payload(8'($urandom));
            end else begin
                if ($urandom_range(0, 99) < 5)
                    len = $urandom_range(128, 255);
                else
                    len = $urandom_range(0, 7);
                count = len;
                if (len > 7)
                    count = $urandom_range(0, 10);
                else if (len > 0 && $urandom_range(0, 99) < 12)
                    count = $urandom_range(0, len - 1);
                send_open(8'($urandom), 8'(len));
                repeat (count) send_payload(8'($urandom));
            end
        end
    endtask

    initial begin
        book       = new();
        gap_pct    = 0;
        stall_pct  = 0;
        hold_req   = 0;
        hold_done  = 0;
        items_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        send_payload(8'hFF);              // dropped, nothing open
        send_open(8'h00, 8'd0);
        send_open(8'hFF, 8'd0);
        send_open(8'h5A, 8'd1);
        send_payload(8'h00);
        send_open(8'h81, 8'd2);
        send_payload(8'hFF);
        send_payload(8'h55);
        send_payload(8'hC3);              // dropped after a closed frame
        send_open(8'h10, 8'd3);
        send_payload(8'h01);
        send_open(8'hA5, 8'd255);         // abandons the open frame
        send_payload(8'h80);
        send_payload(8'h7F);
        send_open(8'h00, 8'd1);
        send_payload(8'h7E);

        // random frames: no idling with one long receiver hold-off, then gaps and stalls
        hold_req = 1;
        random_frames(50);
        gap_pct = 51;
        random_frames(50);
        gap_pct   = 0;
        stall_pct = 51;
        random_frames(50);
        gap_pct   = 29;
        stall_pct = 29;
        random_frames(50);
        random_frames(14);

        s_tvalid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (book.errors == 0)
            $display("tb_crc16_packet_framer OK");
        else
            $display("tb_crc16_packet_framer NOT OK");
        $finish;
    end
endmodule
